// File: rtl/cvc_pkg.sv
// Package for the convex volume cull test: query codes, register map,
// plane packing and the control word that travels down the cell chain.
// No dependencies.
package cvc_pkg;

   // query kinds (code 3 is unused and tests like a sphere)
   localparam logic [1:0] OP_BOX    = 2'd0;
   localparam logic [1:0] OP_SPHERE = 2'd1;
   localparam logic [1:0] OP_POINT  = 2'd2;

   // register map: index = paddr[5:3]
   localparam int         CSR_ADDR_BITS   = 6;
   localparam int         CSR_DATA_BITS   = 64;
   localparam int         CSR_IDX_LSB     = 3;
   localparam logic [2:0] CSR_PLANE_COUNT = 3'd0;
   localparam int         PLANE_REGS      = 6;

   // plane packing: nx, ny, nz Q1.14 and d Q11.4, 16 bits each
   localparam int NORMAL_BITS = 16;
   localparam int NORMAL_FRAC = 14;
   localparam int NX_LSB      = 0;
   localparam int NY_LSB      = 16;
   localparam int NZ_LSB      = 32;
   localparam int D_LSB       = 48;

   typedef logic [CSR_DATA_BITS-1:0] plane_type;

   // control word carried next to each query along the chain
   typedef struct packed {
      logic       valid;
      logic [1:0] opcode;
      logic       in_vol;
   } cell_ctl_type;

endpackage

// File: rtl/convex_volume_cull_test.sv
// Convex volume cull test: a query runs down a chain of MAX_PLANES cells,
// one plane per cell, two register stages per cell.
// The start transfer reaches the rsp_valid strobe through both register stages of every cell.
// Throughput: one query per cycle; busy is high only while reset is high.
// Reset (synchronous) clears all in-flight queries, plane_count and the planes.
// The result strobe lasts one cycle; the receiver cannot stall.
module convex_volume_cull_test #(
   parameter int MAX_PLANES = 6,
   parameter int COORD_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // query channel
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_opcode,
   input  logic signed [COORD_BITS-1:0]         req_center_x,
   input  logic signed [COORD_BITS-1:0]         req_center_y,
   input  logic signed [COORD_BITS-1:0]         req_center_z,
   input  logic signed [COORD_BITS-1:0]         req_half_x,
   input  logic signed [COORD_BITS-1:0]         req_half_y,
   input  logic signed [COORD_BITS-1:0]         req_half_z,
   input  logic signed [COORD_BITS-1:0]         req_margin,
   // result channel
   output logic                                 rsp_valid,
   output logic                                 rsp_inside_res,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [cvc_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [cvc_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [cvc_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                 pready
);
   import cvc_pkg::*;

   localparam int LATENCY = 2 * MAX_PLANES;

   logic [2:0] plane_count;
   plane_type  plane [MAX_PLANES];

   // chain taps: entry k feeds cell k, entry MAX_PLANES is the chain output
   cell_ctl_type                 chain_ctl [MAX_PLANES+1];
   logic signed [COORD_BITS-1:0] chain_cx  [MAX_PLANES+1];
   logic signed [COORD_BITS-1:0] chain_cy  [MAX_PLANES+1];
   logic signed [COORD_BITS-1:0] chain_cz  [MAX_PLANES+1];
   logic        [COORD_BITS-1:0] chain_hx  [MAX_PLANES+1];
   logic        [COORD_BITS-1:0] chain_hy  [MAX_PLANES+1];
   logic        [COORD_BITS-1:0] chain_hz  [MAX_PLANES+1];
   logic signed [COORD_BITS-1:0] chain_mg  [MAX_PLANES+1];

   cvc_csr #(
      .MAX_PLANES (MAX_PLANES)
   ) u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .plane_count_o (plane_count),
      .plane_o       (plane)
   );

   // the chain takes a query every cycle unless reset holds busy high
   assign busy = reset;

   // entry: a new query starts out inside; half sizes go in as magnitudes
   // (the most negative code maps to 2048.0 exactly)
   assign chain_ctl[0] = '{valid: start && !busy, opcode: req_opcode, in_vol: 1'b1};
   assign chain_cx[0]  = req_center_x;
   assign chain_cy[0]  = req_center_y;
   assign chain_cz[0]  = req_center_z;
   assign chain_hx[0]  = req_half_x[COORD_BITS-1] ? (~req_half_x + 1'b1) : req_half_x;
   assign chain_hy[0]  = req_half_y[COORD_BITS-1] ? (~req_half_y + 1'b1) : req_half_y;
   assign chain_hz[0]  = req_half_z[COORD_BITS-1] ? (~req_half_z + 1'b1) : req_half_z;
   assign chain_mg[0]  = req_margin;

   genvar k;
   generate
      for (k = 0; k < MAX_PLANES; k++) begin : g_cell
         logic cell_en;

         // plane k is in use when plane_count exceeds k; counts above
         // MAX_PLANES simply enable every cell
         assign cell_en = {1'b0, plane_count} > 4'(k);

         cvc_cell #(
            .COORD_BITS (COORD_BITS)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .en_i    (cell_en),
            .plane_i (plane[k]),
            .ctl_i   (chain_ctl[k]),
            .cx_i    (chain_cx[k]),
            .cy_i    (chain_cy[k]),
            .cz_i    (chain_cz[k]),
            .hx_i    (chain_hx[k]),
            .hy_i    (chain_hy[k]),
            .hz_i    (chain_hz[k]),
            .mg_i    (chain_mg[k]),
            .ctl_o   (chain_ctl[k+1]),
            .cx_o    (chain_cx[k+1]),
            .cy_o    (chain_cy[k+1]),
            .cz_o    (chain_cz[k+1]),
            .hx_o    (chain_hx[k+1]),
            .hy_o    (chain_hy[k+1]),
            .hz_o    (chain_hz[k+1]),
            .mg_o    (chain_mg[k+1])
         );
      end
   endgenerate

   // chain output is already registered in the last cell
   assign rsp_valid      = chain_ctl[MAX_PLANES].valid;
   assign rsp_inside_res = chain_ctl[MAX_PLANES].in_vol;

   // every accepted query gets its strobe after the fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("query transfer without result");

   // no strobe without a query transfer one latency earlier
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result strobe without query");

endmodule

// File: rtl/cvc_csr.sv
// Configuration registers of the cull test: plane count and plane
// coefficients behind an APB-style port. Depends on cvc_pkg.
module cvc_csr #(
   parameter int MAX_PLANES = 6
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [cvc_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [cvc_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [cvc_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                 pready,
   output logic [2:0]                           plane_count_o,
   output cvc_pkg::plane_type                   plane_o [MAX_PLANES]
);
   import cvc_pkg::*;

   logic       wr_en;
   logic [2:0] reg_idx;
   logic [2:0] plane_count_ff;
   plane_type  plane_ff [MAX_PLANES];

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_IDX_LSB +: 3];

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_count_ff <= '0;
      end else if (wr_en && reg_idx == CSR_PLANE_COUNT) begin
         plane_count_ff <= pwdata[2:0];
      end
   end

   genvar g;
   generate
      for (g = 0; g < MAX_PLANES; g++) begin : g_plane
         if (g < PLANE_REGS) begin : g_reg
            always_ff @(posedge clock) begin
               if (reset) begin
                  plane_ff[g] <= '0;
               end else if (wr_en && reg_idx == 3'(g + 1)) begin
                  plane_ff[g] <= pwdata;
               end
            end
         end else begin : g_none
            // no register reaches this plane, it stays at its reset value
            assign plane_ff[g] = '0;
         end
         assign plane_o[g] = plane_ff[g];
      end
   endgenerate

   assign plane_count_o = plane_count_ff;

   always_comb begin
      prdata = '0;
      if (reg_idx == CSR_PLANE_COUNT) begin
         prdata = CSR_DATA_BITS'(plane_count_ff);
      end
      for (int i = 0; i < MAX_PLANES; i++) begin
         if (i < PLANE_REGS && reg_idx == 3'(i + 1)) begin
            prdata = plane_ff[i];
         end
      end
   end

endmodule

// File: rtl/cvc_cell.sv
// One plane-test cell: stage 1 forms the six products, stage 2 sums,
// compares and folds the verdict into the query's in-volume flag.
// Depends on cvc_pkg.
module cvc_cell #(
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en_i,
   input  cvc_pkg::plane_type            plane_i,
   input  cvc_pkg::cell_ctl_type         ctl_i,
   input  logic signed [COORD_BITS-1:0]  cx_i,
   input  logic signed [COORD_BITS-1:0]  cy_i,
   input  logic signed [COORD_BITS-1:0]  cz_i,
   input  logic        [COORD_BITS-1:0]  hx_i,
   input  logic        [COORD_BITS-1:0]  hy_i,
   input  logic        [COORD_BITS-1:0]  hz_i,
   input  logic signed [COORD_BITS-1:0]  mg_i,
   output cvc_pkg::cell_ctl_type         ctl_o,
   output logic signed [COORD_BITS-1:0]  cx_o,
   output logic signed [COORD_BITS-1:0]  cy_o,
   output logic signed [COORD_BITS-1:0]  cz_o,
   output logic        [COORD_BITS-1:0]  hx_o,
   output logic        [COORD_BITS-1:0]  hy_o,
   output logic        [COORD_BITS-1:0]  hz_o,
   output logic signed [COORD_BITS-1:0]  mg_o
);
   import cvc_pkg::*;

   localparam int PW = COORD_BITS + NORMAL_BITS;      // one product
   localparam int RW = PW + 2;                        // sum of three
   // room for dist plus reach, and for d or margin scaled to Q.18
   localparam int DW = ((RW > NORMAL_BITS + NORMAL_FRAC)
                        ? RW : (NORMAL_BITS + NORMAL_FRAC)) + 3;

   logic signed [NORMAL_BITS-1:0] nx, ny, nz, d;
   logic        [NORMAL_BITS-1:0] anx, any, anz;

   // stage 1
   cell_ctl_type                 s1_ctl_ff;
   logic signed [PW-1:0]         px_ff, py_ff, pz_ff;
   logic        [PW-1:0]         rx_ff, ry_ff, rz_ff;
   logic signed [PW-1:0]         px_in, py_in, pz_in;
   logic        [PW-1:0]         rx_in, ry_in, rz_in;
   logic signed [COORD_BITS-1:0] s1_cx_ff, s1_cy_ff, s1_cz_ff, s1_mg_ff;
   logic        [COORD_BITS-1:0] s1_hx_ff, s1_hy_ff, s1_hz_ff;

   // stage 2
   cell_ctl_type                 s2_ctl_ff, s2_ctl_in;
   logic signed [COORD_BITS-1:0] s2_cx_ff, s2_cy_ff, s2_cz_ff, s2_mg_ff;
   logic        [COORD_BITS-1:0] s2_hx_ff, s2_hy_ff, s2_hz_ff;
   logic        [RW-1:0]         box_reach;
   logic signed [DW-1:0]         plane_dist, reach, slack;

   assign nx = $signed(plane_i[NX_LSB +: NORMAL_BITS]);
   assign ny = $signed(plane_i[NY_LSB +: NORMAL_BITS]);
   assign nz = $signed(plane_i[NZ_LSB +: NORMAL_BITS]);
   assign d  = $signed(plane_i[D_LSB  +: NORMAL_BITS]);

   // |n|; the most negative code maps to 2.0 exactly
   assign anx = nx[NORMAL_BITS-1] ? (~nx + 1'b1) : nx;
   assign any = ny[NORMAL_BITS-1] ? (~ny + 1'b1) : ny;
   assign anz = nz[NORMAL_BITS-1] ? (~nz + 1'b1) : nz;

   assign px_in = cx_i * nx;
   assign py_in = cy_i * ny;
   assign pz_in = cz_i * nz;
   assign rx_in = hx_i * anx;
   assign ry_in = hy_i * any;
   assign rz_in = hz_i * anz;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      py_ff    <= py_in;
      pz_ff    <= pz_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      rz_ff    <= rz_in;
      s1_cx_ff <= cx_i;
      s1_cy_ff <= cy_i;
      s1_cz_ff <= cz_i;
      s1_hx_ff <= hx_i;
      s1_hy_ff <= hy_i;
      s1_hz_ff <= hz_i;
      s1_mg_ff <= mg_i;
   end

   // reject when dist + reach < 0, all in Q.18
   always_comb begin
      box_reach = RW'(rx_ff) + RW'(ry_ff) + RW'(rz_ff);
      plane_dist = DW'(px_ff) + DW'(py_ff) + DW'(pz_ff) - (DW'(d) <<< NORMAL_FRAC);
      case (s1_ctl_ff.opcode)
         OP_BOX:              reach = $signed(DW'(box_reach));
         OP_SPHERE, OP_POINT: reach = DW'(s1_mg_ff) <<< NORMAL_FRAC;
         default:             reach = DW'(s1_mg_ff) <<< NORMAL_FRAC;
      endcase
      slack = plane_dist + reach;
      s2_ctl_in        = s1_ctl_ff;
      s2_ctl_in.in_vol = s1_ctl_ff.in_vol && !(en_i && slack[DW-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else begin
         s2_ctl_ff <= s2_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_cx_ff <= s1_cx_ff;
      s2_cy_ff <= s1_cy_ff;
      s2_cz_ff <= s1_cz_ff;
      s2_hx_ff <= s1_hx_ff;
      s2_hy_ff <= s1_hy_ff;
      s2_hz_ff <= s1_hz_ff;
      s2_mg_ff <= s1_mg_ff;
   end

   assign ctl_o = s2_ctl_ff;
   assign cx_o  = s2_cx_ff;
   assign cy_o  = s2_cy_ff;
   assign cz_o  = s2_cz_ff;
   assign hx_o  = s2_hx_ff;
   assign hy_o  = s2_hy_ff;
   assign hz_o  = s2_hz_ff;
   assign mg_o  = s2_mg_ff;

   // a query rejected upstream never comes back inside
   a_reject_sticky: assert property (@(posedge clock) disable iff (reset)
      (s1_ctl_ff.valid && !s1_ctl_ff.in_vol) |=> !s2_ctl_ff.in_vol)
      else $error("rejected query turned inside");

endmodule

// File: dv/convex_volume_cull_test_tb.sv
// Testbench for convex_volume_cull_test: drives box, sphere and point queries
// against programmed clipping planes and checks every inside/outside result.
// Depends on rtl/cvc_pkg.sv and rtl/convex_volume_cull_test.sv.
module tb;
   import cvc_pkg::*;

   localparam int          PLANES     = 6;
   localparam int          CBITS      = 16;
   localparam int          LATENCY    = 2 * PLANES;
   localparam int          NPHASES    = 8;
   localparam int          PHASE_QRYS = 250;
   localparam longint      CYCLE_CAP  = 400000;
   localparam logic [1:0]  OP_UNUSED  = 2'd3;
   // register index past the last plane: a write there must change nothing
   localparam logic [2:0]  CSR_NONE   = 3'd7;

   typedef enum {PL_AIMED, PL_RAW, PL_EDGE} plane_kind_type;

   typedef struct {
      logic [1:0]              opcode;
      logic signed [CBITS-1:0] center_x;
      logic signed [CBITS-1:0] center_y;
      logic signed [CBITS-1:0] center_z;
      logic signed [CBITS-1:0] half_x;
      logic signed [CBITS-1:0] half_y;
      logic signed [CBITS-1:0] half_z;
      logic signed [CBITS-1:0] margin;
   } query_type;

   // ------------------------------------------------------------------
   // Cull scoreboard: private copy of plane_count and the planes, an
   // exact fixed-point predictor, and the queue of expected verdicts.
   // ------------------------------------------------------------------
   class cull_board;
      logic [2:0]  plane_count;
      plane_type   plane [PLANES];
      bit          inside_q [$];
      int          fails;
      int          kind_seen [4];
      int          n_inside;
      int          n_outside;

      function new();
         plane_count = '0;
         foreach (plane[i]) plane[i] = '0;
         fails     = 0;
         n_inside  = 0;
         n_outside = 0;
         foreach (kind_seen[i]) kind_seen[i] = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [63:0] value);
         if (idx == CSR_PLANE_COUNT) begin
            plane_count = value[2:0];
         end else if (idx <= PLANE_REGS && int'(idx) - 1 < PLANES) begin
            plane[idx - 1] = value;
         end
      endfunction

      function bit predict_inside(query_type q);
         longint cx, cy, cz, hx, hy, hz, mg;
         longint nx, ny, nz, d, plane_dist, reach;
         int     cnt;
         bit     keep;
         cx = longint'(q.center_x);
         cy = longint'(q.center_y);
         cz = longint'(q.center_z);
         hx = longint'(q.half_x);
         hy = longint'(q.half_y);
         hz = longint'(q.half_z);
         // absolute half sizes; -32768 becomes exactly 32768
         if (hx < 0) hx = -hx;
         if (hy < 0) hy = -hy;
         if (hz < 0) hz = -hz;
         mg = longint'(q.margin) <<< NORMAL_FRAC;
         cnt = (int'(plane_count) > PLANES) ? PLANES : int'(plane_count);
         keep = 1'b1;
         for (int i = 0; i < cnt; i++) begin
            nx = longint'($signed(plane[i][NX_LSB +: NORMAL_BITS]));
            ny = longint'($signed(plane[i][NY_LSB +: NORMAL_BITS]));
            nz = longint'($signed(plane[i][NZ_LSB +: NORMAL_BITS]));
            d  = longint'($signed(plane[i][D_LSB +: NORMAL_BITS])) <<< NORMAL_FRAC;
            plane_dist = cx * nx + cy * ny + cz * nz - d;
            if (q.opcode == OP_BOX) begin
               reach = hx * (nx < 0 ? -nx : nx) + hy * (ny < 0 ? -ny : ny)
                     + hz * (nz < 0 ? -nz : nz);
            end else begin
               reach = mg;   // sphere, point and the unused code
            end
            if (plane_dist < -reach) keep = 1'b0;
         end
         return keep;
      endfunction

      function void note_query(query_type q);
         inside_q.insert(inside_q.size(), predict_inside(q));
         kind_seen[q.opcode]++;
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH @%0t: %s", $time, what);
         fails++;
      endtask

      task check_result(logic got);
         bit want;
         if (inside_q.size() == 0) begin
            report_mismatch($sformatf("result %b with no query outstanding", got));
         end else begin
            want = inside_q.pop_front();
            if (got !== want) begin
               report_mismatch($sformatf("inside_res got %b expected %b", got, want));
            end
            if (want) n_inside++;
            else n_outside++;
         end
      endtask

      function int pending();
         return inside_q.size();
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset and the block
   // ------------------------------------------------------------------
   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic [1:0]                     req_opcode;
   logic signed [CBITS-1:0]        req_center_x;
   logic signed [CBITS-1:0]        req_center_y;
   logic signed [CBITS-1:0]        req_center_z;
   logic signed [CBITS-1:0]        req_half_x;
   logic signed [CBITS-1:0]        req_half_y;
   logic signed [CBITS-1:0]        req_half_z;
   logic signed [CBITS-1:0]        req_margin;
   logic                           rsp_valid;
   logic                           rsp_inside_res;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [CSR_ADDR_BITS-1:0]       paddr;
   logic [CSR_DATA_BITS-1:0]       pwdata;
   logic [CSR_DATA_BITS-1:0]       prdata;
   logic                           pready;

   cull_board board;
   longint    cycles;
   int        phases_run;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   convex_volume_cull_test #(
      .MAX_PLANES (PLANES),
      .COORD_BITS (CBITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_center_z   (req_center_z),
      .req_half_x     (req_half_x),
      .req_half_y     (req_half_y),
      .req_half_z     (req_half_z),
      .req_margin     (req_margin),
      .rsp_valid      (rsp_valid),
      .rsp_inside_res (rsp_inside_res),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // Result monitor: the strobe lasts one cycle and cannot be stalled,
   // so every rising edge with rsp_valid high is one transfer.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.check_result(rsp_inside_res);
      end
   end

   // Watchdog: far above the slowest legal run (about 2000 queries with
   // long gaps, the pipeline latency and the register writes).
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_CAP) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Drivers: everything changes at the falling edge
   // ------------------------------------------------------------------

   // APB write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = CSR_ADDR_BITS'(idx) << CSR_IDX_LSB;
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      board.set_reg(idx, value);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // One query transfer; start stays high if the next call follows at once
   task automatic send_query(input query_type q);
      @(negedge clock);
      start        = 1'b1;
      req_opcode   = q.opcode;
      req_center_x = q.center_x;
      req_center_y = q.center_y;
      req_center_z = q.center_z;
      req_half_x   = q.half_x;
      req_half_y   = q.half_y;
      req_half_z   = q.half_z;
      req_margin   = q.margin;
      do @(posedge clock); while (busy);
      board.note_query(q);
   endtask

   task automatic idle_gap(input int n);
      if (n > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Wait until every outstanding query has answered, then let the
   // pipeline settle before touching the registers.
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic logic [15:0] edge16();
      case ($urandom_range(0, 3))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         default: return 16'hffff;
      endcase
   endfunction

   // mostly near the planes, some full range, a few extremes
   function automatic logic [15:0] rand_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return 16'($urandom_range(0, 6000) - 3000);
      else if (r < 9) return 16'($urandom);
      else return edge16();
   endfunction

   function automatic logic [15:0] rand_extent();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return 16'($urandom_range(0, 2400) - 1200);
      else if (r < 9) return 16'($urandom);
      else return edge16();
   endfunction

   function automatic plane_type make_plane(plane_kind_type kind);
      logic [15:0] nx, ny, nz, d;
      case (kind)
         PL_AIMED: begin
            // origin mostly on the inner side, so queries fall both ways
            nx = 16'($urandom_range(0, 32768) - 16384);
            ny = 16'($urandom_range(0, 32768) - 16384);
            nz = 16'($urandom_range(0, 32768) - 16384);
            d  = 16'(-$urandom_range(0, 3000));
         end
         PL_EDGE: begin
            nx = edge16();
            ny = edge16();
            nz = edge16();
            d  = edge16();
         end
         default: begin
            nx = 16'($urandom);
            ny = 16'($urandom);
            nz = 16'($urandom);
            d  = 16'($urandom);
         end
      endcase
      return {d, nz, ny, nx};
   endfunction

   function automatic query_type mk_query(logic [1:0] op, int cx, int cy, int cz,
                                          int hx, int hy, int hz, int mg);
      query_type q;
      q.opcode   = op;
      q.center_x = 16'(cx);
      q.center_y = 16'(cy);
      q.center_z = 16'(cz);
      q.half_x   = 16'(hx);
      q.half_y   = 16'(hy);
      q.half_z   = 16'(hz);
      q.margin   = 16'(mg);
      return q;
   endfunction

   function automatic query_type rand_query();
      query_type q;
      int r;
      r = $urandom_range(0, 9);
      q.opcode   = (r < 4) ? OP_BOX : (r < 7) ? OP_SPHERE : (r < 9) ? OP_POINT : OP_UNUSED;
      q.center_x = rand_coord();
      q.center_y = rand_coord();
      q.center_z = rand_coord();
      q.half_x   = rand_extent();
      q.half_y   = rand_extent();
      q.half_z   = rand_extent();
      q.margin   = rand_extent();
      return q;
   endfunction

   // mostly back-to-back or short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else return $urandom_range(5, 40);
   endfunction

   // Axis-aligned cube of +-1600 (Q11.4 raw) around the origin:
   // even planes face +axis, odd planes face -axis, all with d = -1600.
   task automatic program_cube(input logic [2:0] cnt);
      logic [15:0] one, neg, d;
      one = 16'(1 << NORMAL_FRAC);
      neg = 16'(-(1 << NORMAL_FRAC));
      d   = 16'(-1600);
      csr_write(3'd1, {d, 16'h0, 16'h0, one});
      csr_write(3'd2, {d, 16'h0, 16'h0, neg});
      csr_write(3'd3, {d, 16'h0, one, 16'h0});
      csr_write(3'd4, {d, 16'h0, neg, 16'h0});
      csr_write(3'd5, {d, one, 16'h0, 16'h0});
      csr_write(3'd6, {d, neg, 16'h0, 16'h0});
      csr_write(CSR_PLANE_COUNT, 64'(cnt));
   endtask

   // Directed queries against the cube: exact boundaries, abs of half
   // sizes, negative margins, the unused code and the field extremes.
   task automatic cube_queries();
      send_query(mk_query(OP_POINT,     0,    0,    0,    0,   0,   0,     0));
      send_query(mk_query(OP_POINT,  2000,    0,    0,    0,   0,   0,     0));
      send_query(mk_query(OP_POINT,  2000,    0,    0,    0,   0,   0,   400));
      send_query(mk_query(OP_POINT,  2000,    0,    0,    0,   0,   0,   399));
      send_query(mk_query(OP_SPHERE,    0,-2000,    0,    0,   0,   0,   400));
      send_query(mk_query(OP_SPHERE,    0,-2000,    0,    0,   0,   0,   399));
      send_query(mk_query(OP_BOX,       0,    0, 2000,    0,   0, 400,     0));
      send_query(mk_query(OP_BOX,       0,    0, 2000,    0,   0,-400,     0));
      send_query(mk_query(OP_BOX,       0,    0, 2000,    0,   0, 399,     0));
      send_query(mk_query(OP_UNUSED, 2000,    0,    0,    0,   0,   0,   400));
      send_query(mk_query(OP_UNUSED, 2000,    0,    0,    0,   0,   0,   399));
      // negative margin shrinks the volume
      send_query(mk_query(OP_POINT,  1500,    0,    0,    0,   0,   0,  -100));
      send_query(mk_query(OP_POINT,  1500,    0,    0,    0,   0,   0,  -101));
      // most negative half size counts as 2048.0
      send_query(mk_query(OP_BOX,   32767,32767,32767,-32768,-32768,-32768, 0));
      send_query(mk_query(OP_BOX,  -32768,-32768,-32768, 32767, 32767, 32767, 0));
      send_query(mk_query(OP_SPHERE,-32768,32767,-32768, 0, 0, 0, 32767));
      send_query(mk_query(OP_POINT, 32767,-32768,32767, 0, 0, 0, -32768));
   endtask

   task automatic program_phase(input int p);
      logic [2:0]     cnt;
      plane_kind_type kind;
      int             r;
      // count 7 checks the clamp to six planes, count 0 passes everything
      cnt = (p == 0) ? 3'd7 : (p == 1) ? 3'd0 : (p == 2) ? 3'd6 : 3'($urandom_range(1, 7));
      for (int i = 0; i < PLANES; i++) begin
         r = $urandom_range(0, 19);
         if (p == 3) kind = PL_RAW;
         else if (p == 4) kind = PL_EDGE;
         else kind = (r < 14) ? PL_AIMED : (r < 17) ? PL_RAW : PL_EDGE;
         csr_write(3'(i + 1), make_plane(kind));
      end
      // upper bits of the count write carry junk; only [2:0] matters
      csr_write(CSR_PLANE_COUNT, {$urandom, 29'($urandom), cnt});
      if ($urandom_range(0, 1)) csr_write(CSR_NONE, {$urandom, $urandom});
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      bit steady;
      board        = new();
      cycles       = 0;
      phases_run   = 0;
      reset        = 1'b1;
      start        = 1'b0;
      req_opcode   = OP_BOX;
      req_center_x = '0;
      req_center_y = '0;
      req_center_z = '0;
      req_half_x   = '0;
      req_half_y   = '0;
      req_half_z   = '0;
      req_margin   = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset state: no planes in use, everything is inside
      send_query(mk_query(OP_POINT, -32768, -32768, -32768, 0, 0, 0, -32768));
      send_query(mk_query(OP_BOX, 32767, 32767, 32767, 0, 0, 0, 0));
      drain();

      program_cube(3'd6);
      cube_queries();
      drain();

      // same cube with count 7 (clamped) and a write to the spare index
      program_cube(3'd7);
      csr_write(CSR_NONE, 64'hffff_ffff_ffff_ffff);
      send_query(mk_query(OP_POINT, 2000, 0, 0, 0, 0, 0, 399));
      send_query(mk_query(OP_BOX, 0, 0, 2000, 0, 0, 400, 0));
      send_query(mk_query(OP_POINT, 0, 0, 0, 0, 0, 0, 0));
      drain();
      phases_run = 3;

      // random phases, each with its own plane setting
      for (int p = 0; p < NPHASES; p++) begin
         program_phase(p);
         steady = 1'b0;
         for (int n = 0; n < PHASE_QRYS; n++) begin
            // occasional stretches of back-to-back transfers
            if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
            send_query(rand_query());
            if (!steady) idle_gap(pick_gap());
         end
         drain();
         phases_run++;
      end

      $display("Ran %0d queries (box %0d, sphere %0d, point %0d, unused code %0d)",
               board.kind_seen[0] + board.kind_seen[1] + board.kind_seen[2]
               + board.kind_seen[3], board.kind_seen[0], board.kind_seen[1],
               board.kind_seen[2], board.kind_seen[3]);
      $display("over %0d plane settings: %0d inside, %0d culled, %0d mismatches",
               phases_run, board.n_inside, board.n_outside, board.fails);
      if (board.fails == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
